// File: rtl/cubic_bezier_point_generator_macros.svh
// Assertion macros for the cubic Bezier point generator.
// Included by the top level; depends on nothing else.
`ifndef CUBIC_BEZIER_POINT_GENERATOR_MACROS_SVH
`define CUBIC_BEZIER_POINT_GENERATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCG_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/bcg_pkg.sv
// Shared constants, types and helper functions of the cubic Bezier point generator.
// Depends on nothing; every other file but the macros header imports it.
package bcg_pkg;

   localparam int DEF_MAX_POINTS  = 64;
   localparam int DEF_COORD_WIDTH = 24;
   localparam int DEF_T_FRAC_BITS = 16;

   localparam int COUNT_W     = 7;
   localparam int INDEX_W     = 6;
   localparam int NUM_COORDS  = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam int SLOT_START_X = 0;
   localparam int SLOT_START_Y = 1;
   localparam int SLOT_CTRL1_X = 2;
   localparam int SLOT_CTRL1_Y = 3;
   localparam int SLOT_CTRL2_X = 4;
   localparam int SLOT_CTRL2_Y = 5;
   localparam int SLOT_END_X   = 6;
   localparam int SLOT_END_Y   = 7;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Queue entry: coordinates, point count, step quotient and step remainder.
   function automatic int entry_width(int coord_width, int t_frac_bits, int cnt_w);
      return NUM_COORDS * coord_width + cnt_w + (t_frac_bits + 1) + cnt_w;
   endfunction

endpackage

// File: rtl/bcg_if.sv
// Valid/ready channel interfaces for curve requests and curve point responses.
// Depends on bcg_pkg.
interface bcg_req_if #(
   parameter int COORD_WIDTH = bcg_pkg::DEF_COORD_WIDTH
);
   import bcg_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] start_x;
   logic signed [COORD_WIDTH-1:0] start_y;
   logic signed [COORD_WIDTH-1:0] ctrl1_x;
   logic signed [COORD_WIDTH-1:0] ctrl1_y;
   logic signed [COORD_WIDTH-1:0] ctrl2_x;
   logic signed [COORD_WIDTH-1:0] ctrl2_y;
   logic signed [COORD_WIDTH-1:0] end_x;
   logic signed [COORD_WIDTH-1:0] end_y;
   logic [COUNT_W-1:0]            point_count;

   modport source (
      output valid, start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y,
      output point_count,
      input  ready
   );

   modport sink (
      input  valid, start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y,
      input  point_count,
      output ready
   );
endinterface

interface bcg_rsp_if #(
   parameter int COORD_WIDTH = bcg_pkg::DEF_COORD_WIDTH
);
   import bcg_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic [INDEX_W-1:0]            point_index;
   logic                          last;

   modport source (
      output valid, point_x, point_y, point_index, last,
      input  ready
   );

   modport sink (
      input  valid, point_x, point_y, point_index, last,
      output ready
   );
endinterface

// File: rtl/bcg_queue.sv
// Short first-word-fallthrough queue between the front and back parts.
// Depends on bcg_pkg.
module bcg_queue #(
   parameter int WIDTH = bcg_pkg::entry_width(bcg_pkg::DEF_COORD_WIDTH,
                                              bcg_pkg::DEF_T_FRAC_BITS, bcg_pkg::COUNT_W),
   parameter int DEPTH = bcg_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output logic [WIDTH-1:0]          pop_data,
   output bcg_pkg::queue_status_type qstat
);
   import bcg_pkg::*;

   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]  LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

   logic [WIDTH-1:0]  mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data    = mem_ff[rd_ptr_ff];
   assign qstat.full  = (fill_ff == FULL_FILL);
   assign qstat.empty = (fill_ff == '0);

endmodule

// File: rtl/bcg_front.sv
// Front part: takes curve beats, clamps the point count, drops empty curves and
// works out the per-point step of t by restoring division. Depends on bcg_pkg, bcg_if.
module bcg_front #(
   parameter int MAX_POINTS  = bcg_pkg::DEF_MAX_POINTS,
   parameter int COORD_WIDTH = bcg_pkg::DEF_COORD_WIDTH,
   parameter int T_FRAC_BITS = bcg_pkg::DEF_T_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   bcg_req_if.sink                   req_bus,
   input  bcg_pkg::queue_status_type qstat,
   output logic                      push,
   output logic [bcg_pkg::entry_width(COORD_WIDTH, T_FRAC_BITS,
                                      $clog2(MAX_POINTS + 1))-1:0] push_data
);
   import bcg_pkg::*;

   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int SW    = $clog2(T_FRAC_BITS + 1);
   localparam logic [COUNT_W-1:0] MAX_CNT  = COUNT_W'(MAX_POINTS);
   localparam logic [SW-1:0]      TOP_STEP = SW'(T_FRAC_BITS);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_DIV  = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type                   state_ff, state_in;
   logic [NUM_COORDS*COORD_WIDTH-1:0] coords_ff, coords_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [CNT_W-1:0]                  rem_ff, rem_in;
   logic [T_FRAC_BITS:0]              quo_ff, quo_in;
   logic [SW-1:0]                     step_ff, step_in;

   logic               accept;
   logic [COUNT_W-1:0] sat_count;
   logic [CNT_W:0]     shifted;
   logic [CNT_W:0]     reduced;
   logic               qbit;

   always_comb begin
      accept    = req_bus.valid && req_bus.ready;
      sat_count = (req_bus.point_count > MAX_CNT) ? MAX_CNT : req_bus.point_count;
      // The dividend is a single one at bit T_FRAC_BITS.
      shifted   = {rem_ff, (step_ff == TOP_STEP)};
      reduced   = shifted - {1'b0, count_ff};
      qbit      = (shifted >= {1'b0, count_ff});

      state_in  = state_ff;
      coords_in = coords_ff;
      count_in  = count_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      step_in   = step_ff;

      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               coords_in[SLOT_START_X*COORD_WIDTH +: COORD_WIDTH] = req_bus.start_x;
               coords_in[SLOT_START_Y*COORD_WIDTH +: COORD_WIDTH] = req_bus.start_y;
               coords_in[SLOT_CTRL1_X*COORD_WIDTH +: COORD_WIDTH] = req_bus.ctrl1_x;
               coords_in[SLOT_CTRL1_Y*COORD_WIDTH +: COORD_WIDTH] = req_bus.ctrl1_y;
               coords_in[SLOT_CTRL2_X*COORD_WIDTH +: COORD_WIDTH] = req_bus.ctrl2_x;
               coords_in[SLOT_CTRL2_Y*COORD_WIDTH +: COORD_WIDTH] = req_bus.ctrl2_y;
               coords_in[SLOT_END_X*COORD_WIDTH +: COORD_WIDTH]   = req_bus.end_x;
               coords_in[SLOT_END_Y*COORD_WIDTH +: COORD_WIDTH]   = req_bus.end_y;
               count_in = sat_count[CNT_W-1:0];
               rem_in   = '0;
               quo_in   = '0;
               step_in  = TOP_STEP;
               if (sat_count != '0) begin
                  state_in = F_DIV;
               end
            end
         end
         F_DIV: begin
            rem_in  = qbit ? reduced[CNT_W-1:0] : shifted[CNT_W-1:0];
            quo_in  = {quo_ff[T_FRAC_BITS-1:0], qbit};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!qstat.full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      coords_ff <= coords_in;
      count_ff  <= count_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      step_ff   <= step_in;
   end

   assign req_bus.ready = (state_ff == F_IDLE);
   assign push          = (state_ff == F_PUSH) && !qstat.full;
   assign push_data     = {coords_ff, count_ff, quo_ff, rem_ff};

endmodule

// File: rtl/bcg_back.sv
// Back part: steps t across the run and evaluates each point through a six-stage
// de Casteljau pipeline ending in the response register. Depends on bcg_pkg, bcg_if.
module bcg_back #(
   parameter int MAX_POINTS  = bcg_pkg::DEF_MAX_POINTS,
   parameter int COORD_WIDTH = bcg_pkg::DEF_COORD_WIDTH,
   parameter int T_FRAC_BITS = bcg_pkg::DEF_T_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  bcg_pkg::queue_status_type qstat,
   input  logic [bcg_pkg::entry_width(COORD_WIDTH, T_FRAC_BITS,
                                      $clog2(MAX_POINTS + 1))-1:0] pop_data,
   output logic                      pop,
   output logic                      gen_idle,
   bcg_rsp_if.source                 rsp_bus
);
   import bcg_pkg::*;

   localparam int CNT_W     = $clog2(MAX_POINTS + 1);
   localparam int IDX_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int DW        = COORD_WIDTH + 1;
   localparam int PW        = DW + T_FRAC_BITS + 1;
   localparam int R0_LSB    = 0;
   localparam int Q0_LSB    = CNT_W;
   localparam int CNT_LSB   = CNT_W + T_FRAC_BITS + 1;
   localparam int COORD_LSB = 2 * CNT_W + T_FRAC_BITS + 1;
   localparam int STAGES    = 6;

   logic                              active_ff;
   logic [NUM_COORDS*COORD_WIDTH-1:0] held_ff;
   logic [CNT_W-1:0]                  cnt_ff;
   logic [T_FRAC_BITS:0]              q0_ff;
   logic [CNT_W-1:0]                  r0_ff;
   logic [T_FRAC_BITS-1:0]            t_ff, t_in;
   logic [CNT_W-1:0]                  r_ff, r_in;
   logic [IDX_W-1:0]                  idx_ff;

   logic [STAGES-1:0]      valid_ff;
   logic [T_FRAC_BITS-1:0] t_pipe_ff    [4];
   logic [IDX_W-1:0]       idx_pipe_ff  [STAGES];
   logic [STAGES-1:0]      last_pipe_ff;

   logic signed [PW-1:0]          prod1_ff [2][3];
   logic signed [COORD_WIDTH-1:0] base1_ff [2][3];
   logic signed [COORD_WIDTH-1:0] lv1_ff   [2][3];
   logic signed [PW-1:0]          prod2_ff [2][2];
   logic signed [COORD_WIDTH-1:0] base2_ff [2][2];
   logic signed [COORD_WIDTH-1:0] lv2_ff   [2][2];
   logic signed [PW-1:0]          prod3_ff [2];
   logic signed [COORD_WIDTH-1:0] base3_ff [2];
   logic signed [COORD_WIDTH-1:0] point_ff [2];

   logic           advance;
   logic           issue;
   logic           is_last;
   logic [CNT_W:0] rsum;
   logic [CNT_W:0] rdiff;
   logic           wrap;

   function automatic logic signed [PW-1:0] scale_diff(
      input logic signed [COORD_WIDTH-1:0] a,
      input logic signed [COORD_WIDTH-1:0] b,
      input logic [T_FRAC_BITS-1:0]        t
   );
      logic signed [DW-1:0] d;
      logic signed [PW-1:0] te;
      d  = DW'(b) - DW'(a);
      te = PW'($signed({1'b0, t}));
      return PW'(d) * te;
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] add_scaled(
      input logic signed [COORD_WIDTH-1:0] a,
      input logic signed [PW-1:0]          p
   );
      logic signed [PW-1:0] s;
      s = (p >>> T_FRAC_BITS) + PW'(a);
      return s[COORD_WIDTH-1:0];
   endfunction

   // t advances by the quotient and remainder of 2^T_FRAC_BITS over the count.
   always_comb begin
      advance = !valid_ff[STAGES-1] || rsp_bus.ready;
      issue   = active_ff && advance;
      pop     = !active_ff && !qstat.empty;
      is_last = ((CNT_W'(idx_ff) + 1'b1) == cnt_ff);
      rsum    = {1'b0, r_ff} + {1'b0, r0_ff};
      rdiff   = rsum - {1'b0, cnt_ff};
      wrap    = (rsum >= {1'b0, cnt_ff});
      t_in    = T_FRAC_BITS'({1'b0, t_ff} + q0_ff + (T_FRAC_BITS + 1)'(wrap));
      r_in    = wrap ? rdiff[CNT_W-1:0] : rsum[CNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (pop) begin
         active_ff <= 1'b1;
      end else if (issue && is_last) begin
         active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         held_ff <= pop_data[COORD_LSB +: NUM_COORDS*COORD_WIDTH];
         cnt_ff  <= pop_data[CNT_LSB +: CNT_W];
         q0_ff   <= pop_data[Q0_LSB +: T_FRAC_BITS + 1];
         r0_ff   <= pop_data[R0_LSB +: CNT_W];
         t_ff    <= '0;
         r_ff    <= '0;
         idx_ff  <= '0;
      end else if (issue && !is_last) begin
         t_ff    <= t_in;
         r_ff    <= r_in;
         idx_ff  <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[STAGES-2:0], issue};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t_pipe_ff[0]    <= t_ff;
         idx_pipe_ff[0]  <= idx_ff;
         last_pipe_ff[0] <= is_last;
         for (int s = 1; s < 4; s++) begin
            t_pipe_ff[s] <= t_pipe_ff[s-1];
         end
         for (int s = 1; s < STAGES; s++) begin
            idx_pipe_ff[s]  <= idx_pipe_ff[s-1];
            last_pipe_ff[s] <= last_pipe_ff[s-1];
         end
         for (int ax = 0; ax < 2; ax++) begin
            for (int k = 0; k < 3; k++) begin
               prod1_ff[ax][k] <= scale_diff(
                  held_ff[(SLOT_START_X + 2*k + ax)*COORD_WIDTH +: COORD_WIDTH],
                  held_ff[(SLOT_START_X + 2*k + 2 + ax)*COORD_WIDTH +: COORD_WIDTH],
                  t_ff);
               base1_ff[ax][k] <=
                  held_ff[(SLOT_START_X + 2*k + ax)*COORD_WIDTH +: COORD_WIDTH];
               lv1_ff[ax][k]   <= add_scaled(base1_ff[ax][k], prod1_ff[ax][k]);
            end
            for (int k = 0; k < 2; k++) begin
               prod2_ff[ax][k] <= scale_diff(lv1_ff[ax][k], lv1_ff[ax][k+1], t_pipe_ff[1]);
               base2_ff[ax][k] <= lv1_ff[ax][k];
               lv2_ff[ax][k]   <= add_scaled(base2_ff[ax][k], prod2_ff[ax][k]);
            end
            prod3_ff[ax] <= scale_diff(lv2_ff[ax][0], lv2_ff[ax][1], t_pipe_ff[3]);
            base3_ff[ax] <= lv2_ff[ax][0];
            point_ff[ax] <= add_scaled(base3_ff[ax], prod3_ff[ax]);
         end
      end
   end

   assign gen_idle            = !active_ff;
   assign rsp_bus.valid       = valid_ff[STAGES-1];
   assign rsp_bus.point_x     = point_ff[0];
   assign rsp_bus.point_y     = point_ff[1];
   assign rsp_bus.point_index = INDEX_W'(idx_pipe_ff[STAGES-1]);
   assign rsp_bus.last        = last_pipe_ff[STAGES-1];

endmodule

// File: rtl/cubic_bezier_point_generator.sv
// Top level of the cubic Bezier point generator: front part, queue and back part.
// Depends on bcg_pkg, bcg_if, bcg_queue, bcg_front, bcg_back and the macros header.
//
// Each request beat on req_bus carries one cubic curve (start, two control points,
// end) and a point count N. Counts above MAX_POINTS are clamped; a count of zero is
// taken and produces nothing. For every other curve the block sends N response
// beats on rsp_bus, point i at t = i/N, with last set on the final one.
// The front part takes a curve, finds the step of t in a restoring divider and
// writes the curve into a two-entry queue; it takes no new curve until the last
// one has been written into the queue.
// The back part pops a curve and then, while rsp_bus is not stalled, issues one
// point per cycle into a six-stage interpolation pipeline whose last stage is the
// response register.
// While rsp_bus is stalled the whole back pipeline holds; the queue then fills
// and the front part stops taking requests.
// Reset is synchronous: it empties the queue and clears all valid state.
module cubic_bezier_point_generator #(
   parameter int MAX_POINTS  = bcg_pkg::DEF_MAX_POINTS,
   parameter int COORD_WIDTH = bcg_pkg::DEF_COORD_WIDTH,
   parameter int T_FRAC_BITS = bcg_pkg::DEF_T_FRAC_BITS
) (
   input  logic      clock,
   input  logic      reset,
   bcg_req_if.sink   req_bus,
   bcg_rsp_if.source rsp_bus
);
   import bcg_pkg::*;

`include "cubic_bezier_point_generator_macros.svh"

   localparam int CNT_W   = $clog2(MAX_POINTS + 1);
   localparam int ENTRY_W = entry_width(COORD_WIDTH, T_FRAC_BITS, CNT_W);

   logic               push;
   logic [ENTRY_W-1:0] push_data;
   logic               pop;
   logic [ENTRY_W-1:0] pop_data;
   logic               gen_idle;
   logic               zero_taken;
   queue_status_type   qstat;

   bcg_front #(
      .MAX_POINTS  (MAX_POINTS),
      .COORD_WIDTH (COORD_WIDTH),
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .qstat     (qstat),
      .push      (push),
      .push_data (push_data)
   );

   bcg_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .qstat     (qstat)
   );

   bcg_back #(
      .MAX_POINTS  (MAX_POINTS),
      .COORD_WIDTH (COORD_WIDTH),
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .qstat    (qstat),
      .pop_data (pop_data),
      .pop      (pop),
      .gen_idle (gen_idle),
      .rsp_bus  (rsp_bus)
   );

   assign zero_taken = req_bus.valid && req_bus.ready && (req_bus.point_count == '0);

   `BCG_ASSERT_IMPLIES(a_push_room, clock, reset, push, !qstat.full, "Queue written while full.")
   `BCG_ASSERT_IMPLIES(a_pop_data, clock, reset, pop, !qstat.empty, "Queue read while empty.")
   `BCG_ASSERT_NEXT(a_pop_starts_run, clock, reset, pop, !gen_idle, "Pop did not start a run.")
   `BCG_ASSERT_NEXT(a_zero_count_dropped, clock, reset, zero_taken, req_bus.ready, "Empty curve held.")

endmodule
